/* rtl/sbmg_pkg.sv */
// ============================================================================
// sbmg_pkg: shared types and constants for the seed block match unit
// Field structs, opcodes, register indexes and the datapath command/status.
// ============================================================================
package sbmg_pkg;

    localparam int MAX_DIM    = 256;
    localparam int MAX_SEED   = 16;
    localparam int PIXEL_BITS = 24;

    localparam int CW = $clog2(MAX_DIM);      // coordinate bits
    localparam int DW = CW + 1;               // extent bits
    localparam int SW = $clog2(MAX_SEED) + 1; // seed bits
    localparam int AW = 2 * CW;               // store address bits

    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    localparam logic [2:0] REG_SEED     = 3'd0;
    localparam logic [2:0] REG_WIDTH_A  = 3'd1;
    localparam logic [2:0] REG_HEIGHT_A = 3'd2;
    localparam logic [2:0] REG_WIDTH_B  = 3'd3;
    localparam logic [2:0] REG_HEIGHT_B = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  pix_x;
        logic [7:0]  pix_y;
        logic [23:0] pix_value;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [7:0] a_col;
        logic [7:0] a_row;
        logic [7:0] b_col;
        logic [7:0] b_row;
        logic [8:0] match_width;
        logic [8:0] match_height;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic init;       // load effective config, clear positions
        logic rd;         // issue store reads at current compare address
        logic cmp_next;   // advance the inner compare index
        logic seed_next;  // advance the seed position (raster)
        logic grow_w;     // accept column: w++, reset k
        logic grow_h;     // accept row: h++, reset k
        logic start_row;  // reset k for row growth
        logic found;      // record hit
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic none;       // no seed position at all
        logic seed_last;  // current seed position is the last one
        logic cmp_last;   // current compare index is the last of its scan
        logic col_ok;     // another column fits in both images
        logic row_ok;     // another row fits in both images
        logic eq;         // registered read data equal
    } dp_sts_t;

endpackage

/* rtl/sbmg_ram.sv */
// ============================================================================
// sbmg_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ============================================================================
module sbmg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/sbmg_datapath.sv */
// ============================================================================
// sbmg_datapath: position counters, store addressing and pixel compare
// Holds seed/grow coordinates, both image stores and the compare result.
// ============================================================================
module sbmg_datapath import sbmg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    input  logic              ld_we,
    input  in_item_t          ld_item,
    input  logic [SW-1:0]     cfg_seed,
    input  logic [DW-1:0]     cfg_wa,
    input  logic [DW-1:0]     cfg_ha,
    input  logic [DW-1:0]     cfg_wb,
    input  logic [DW-1:0]     cfg_hb,
    output dp_sts_t           sts,
    output out_item_t         result
);

    logic [DW-1:0] s_reg, wa_reg, ha_reg, wb_reg, hb_reg;
    logic [CW-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [CW-1:0] cx_reg, cy_reg;     // compare offsets inside the seed
    logic [DW-1:0] k_reg;              // index along grown edge
    logic [DW-1:0] w_reg, h_reg;
    logic          found_reg;
    logic          mode_row_reg;       // 0 col scan, 1 row scan (grow)
    logic          growing_reg;

    logic [DW-1:0] s_eff, wa_eff, ha_eff, wb_eff, hb_eff;
    logic [DW-1:0] lim_ax, lim_ay, lim_bx, lim_by;
    logic [DW-1:0] pxa, pya, pxb, pyb;
    logic [AW-1:0] addr_a, addr_b;
    logic [PIXEL_BITS-1:0] rd_a, rd_b;
    logic          ld_a, ld_b;

    function automatic logic [DW-1:0] clamp(input logic [DW-1:0] v);
        return (v > DW'(MAX_DIM)) ? DW'(MAX_DIM) : v;
    endfunction

    always_comb begin
        if (cfg_seed == '0) s_eff = DW'(1);
        else if (DW'(cfg_seed) > DW'(MAX_SEED)) s_eff = DW'(MAX_SEED);
        else s_eff = DW'(cfg_seed);
        wa_eff = clamp(cfg_wa);
        ha_eff = clamp(cfg_ha);
        wb_eff = clamp(cfg_wb);
        hb_eff = clamp(cfg_hb);
    end

    // last valid seed coordinate = extent - s - 1
    assign lim_ax = wa_reg - s_reg - DW'(1);
    assign lim_ay = ha_reg - s_reg - DW'(1);
    assign lim_bx = wb_reg - s_reg - DW'(1);
    assign lim_by = hb_reg - s_reg - DW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg   <= 1'b0;
            growing_reg <= 1'b0;
        end else if (cmd.init) begin
            s_reg <= s_eff; wa_reg <= wa_eff; ha_reg <= ha_eff;
            wb_reg <= wb_eff; hb_reg <= hb_eff;
            ax_reg <= '0; ay_reg <= '0; bx_reg <= '0; by_reg <= '0;
            cx_reg <= '0; cy_reg <= '0;
            found_reg <= 1'b0; growing_reg <= 1'b0; mode_row_reg <= 1'b0;
            w_reg <= '0; h_reg <= '0; k_reg <= '0;
        end else begin
            if (cmd.cmp_next) begin
                if (growing_reg) begin
                    k_reg <= k_reg + DW'(1);
                end else if (DW'(cy_reg) == s_reg - DW'(1)) begin
                    cy_reg <= '0;
                    cx_reg <= cx_reg + CW'(1);
                end else begin
                    cy_reg <= cy_reg + CW'(1);
                end
            end
            if (cmd.seed_next) begin
                cx_reg <= '0; cy_reg <= '0;
                if (DW'(by_reg) != lim_by) by_reg <= by_reg + CW'(1);
                else begin
                    by_reg <= '0;
                    if (DW'(bx_reg) != lim_bx) bx_reg <= bx_reg + CW'(1);
                    else begin
                        bx_reg <= '0;
                        if (DW'(ay_reg) != lim_ay) ay_reg <= ay_reg + CW'(1);
                        else begin
                            ay_reg <= '0;
                            ax_reg <= ax_reg + CW'(1);
                        end
                    end
                end
            end
            if (cmd.found) begin
                found_reg <= 1'b1; growing_reg <= 1'b1; mode_row_reg <= 1'b0;
                w_reg <= s_reg; h_reg <= s_reg; k_reg <= '0;
            end
            if (cmd.grow_w) begin
                w_reg <= w_reg + DW'(1); k_reg <= '0;
            end
            if (cmd.grow_h) begin
                h_reg <= h_reg + DW'(1); k_reg <= '0;
            end
            if (cmd.start_row) begin
                mode_row_reg <= 1'b1; k_reg <= '0;
            end
        end
    end

    always_comb begin
        if (!growing_reg) begin
            pxa = DW'(ax_reg) + DW'(cx_reg); pya = DW'(ay_reg) + DW'(cy_reg);
            pxb = DW'(bx_reg) + DW'(cx_reg); pyb = DW'(by_reg) + DW'(cy_reg);
        end else if (!mode_row_reg) begin
            pxa = DW'(ax_reg) + w_reg; pya = DW'(ay_reg) + k_reg;
            pxb = DW'(bx_reg) + w_reg; pyb = DW'(by_reg) + k_reg;
        end else begin
            pxa = DW'(ax_reg) + k_reg; pya = DW'(ay_reg) + h_reg;
            pxb = DW'(bx_reg) + k_reg; pyb = DW'(by_reg) + h_reg;
        end
    end

    assign ld_a = ld_we && ld_item.opcode == OP_LOAD_A;
    assign ld_b = ld_we && ld_item.opcode == OP_LOAD_B;
    assign addr_a = ld_a ? {ld_item.pix_y, ld_item.pix_x} : {pya[CW-1:0], pxa[CW-1:0]};
    assign addr_b = ld_b ? {ld_item.pix_y, ld_item.pix_x} : {pyb[CW-1:0], pxb[CW-1:0]};

    sbmg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_a (
        .aclk(aclk), .we(ld_a), .addr(addr_a),
        .wdata(ld_item.pix_value[PIXEL_BITS-1:0]), .rdata(rd_a)
    );
    sbmg_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_b (
        .aclk(aclk), .we(ld_b), .addr(addr_b),
        .wdata(ld_item.pix_value[PIXEL_BITS-1:0]), .rdata(rd_b)
    );

    always_comb begin
        sts.none = (wa_reg <= s_reg) || (ha_reg <= s_reg) ||
                   (wb_reg <= s_reg) || (hb_reg <= s_reg);
        sts.seed_last = DW'(by_reg) == lim_by && DW'(bx_reg) == lim_bx &&
                        DW'(ay_reg) == lim_ay && DW'(ax_reg) == lim_ax;
        if (!growing_reg)
            sts.cmp_last = DW'(cx_reg) == s_reg - DW'(1) &&
                           DW'(cy_reg) == s_reg - DW'(1);
        else if (!mode_row_reg)
            sts.cmp_last = k_reg == h_reg - DW'(1);
        else
            sts.cmp_last = k_reg == w_reg - DW'(1);
        sts.col_ok = (DW'(ax_reg) + w_reg < wa_reg) && (DW'(bx_reg) + w_reg < wb_reg);
        sts.row_ok = (DW'(ay_reg) + h_reg < ha_reg) && (DW'(by_reg) + h_reg < hb_reg);
        sts.eq = rd_a == rd_b;
    end

    always_comb begin
        result = '0;
        if (found_reg) begin
            result.found = 1'b1;
            result.a_col = ax_reg; result.a_row = ay_reg;
            result.b_col = bx_reg; result.b_row = by_reg;
            result.match_width = w_reg; result.match_height = h_reg;
        end
    end

endmodule

/* rtl/sbmg_ctrl.sv */
// ============================================================================
// sbmg_ctrl: sequencer for seed search and region growth
// Issues one store read per step and checks the compare once the registered read data is back.
// ============================================================================
module sbmg_ctrl import sbmg_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    start,
    input  dp_sts_t sts,
    input  logic    res_taken,
    output dp_cmd_t cmd,
    output logic    busy,
    output logic    res_valid
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_INIT, ST_SEED_RD, ST_SEED_CHK,
        ST_COL_CHK0, ST_COL_RD, ST_ROW_CHK0, ST_ROW_RD
    } state_t;

    state_t state_reg;
    logic   res_valid_reg;
    logic   busy_reg;

    // ST_*_RD: address presented, data arrives next cycle (ST_*_CHK style).
    // Col/row scans reuse RD state with a pending flag.
    logic   pend_reg;

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:     ;
            ST_INIT:     ;
            ST_SEED_RD:  ;
            ST_SEED_CHK: begin
                if (!sts.eq) cmd.seed_next = !sts.seed_last;
                else if (!sts.cmp_last) cmd.cmp_next = 1'b1;
                else cmd.found = 1'b1;
            end
            ST_COL_CHK0: begin
                // no room for another column: switch to row growth
                cmd.start_row = !sts.col_ok;
            end
            ST_COL_RD: begin
                if (pend_reg && sts.eq) begin
                    if (sts.cmp_last) cmd.grow_w = 1'b1;
                    else cmd.cmp_next = 1'b1;
                end else if (pend_reg) cmd.start_row = 1'b1;
            end
            ST_ROW_CHK0: ;
            ST_ROW_RD: begin
                if (pend_reg && sts.eq) begin
                    if (sts.cmp_last) cmd.grow_h = 1'b1;
                    else cmd.cmp_next = 1'b1;
                end
            end
            default: ;
        endcase
        cmd.init = (state_reg == ST_IDLE) && start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            if (res_valid_reg && res_taken) res_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_INIT;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_INIT: begin
                    if (sts.none) begin
                        state_reg <= ST_IDLE; busy_reg <= 1'b0;
                        res_valid_reg <= 1'b1;
                    end else state_reg <= ST_SEED_RD;
                end
                ST_SEED_RD: state_reg <= ST_SEED_CHK;
                ST_SEED_CHK: begin
                    if (!sts.eq && sts.seed_last) begin
                        state_reg <= ST_IDLE; busy_reg <= 1'b0;
                        res_valid_reg <= 1'b1;
                    end else if (sts.eq && sts.cmp_last) state_reg <= ST_COL_CHK0;
                    else state_reg <= ST_SEED_RD;
                end
                ST_COL_CHK0: begin
                    if (sts.col_ok) state_reg <= ST_COL_RD;
                    else state_reg <= ST_ROW_CHK0;
                end
                ST_COL_RD: begin
                    if (!pend_reg) pend_reg <= 1'b1;
                    else if (!sts.eq) state_reg <= ST_ROW_CHK0;
                    else if (sts.cmp_last) state_reg <= ST_COL_CHK0;
                end
                ST_ROW_CHK0: begin
                    if (sts.row_ok) state_reg <= ST_ROW_RD;
                    else begin
                        state_reg <= ST_IDLE; busy_reg <= 1'b0;
                        res_valid_reg <= 1'b1;
                    end
                end
                ST_ROW_RD: begin
                    if (!pend_reg) pend_reg <= 1'b1;
                    else if (!sts.eq) begin
                        state_reg <= ST_IDLE; busy_reg <= 1'b0;
                        res_valid_reg <= 1'b1;
                    end else if (sts.cmp_last) state_reg <= ST_ROW_CHK0;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy      = busy_reg;
    assign res_valid = res_valid_reg;

`ifndef SYNTHESIS
    a_idle_no_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !busy_reg) else $error("busy in idle");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && state_reg != ST_IDLE) |=> (busy_reg || res_valid_reg))
        else $error("search ended without result");
    a_one_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.grow_w && cmd.grow_h)) else $error("grow both ways");
`endif

endmodule

/* rtl/seed_block_match_and_grow_unit.sv */
// ============================================================================
// seed_block_match_and_grow_unit: exhaustive seed block match with growth
// Top level: request channels, APB register file, controller and datapath.
// ============================================================================
// Usage: s_ channel carries requests. Load requests (opcode 0/1) write one
// pixel of image A or B, one per cycle while no search runs, with no
// result. A start request (opcode 2) runs the search and returns one result
// on the m_ channel. Opcode 3 is ignored.
// Each pixel compare goes through the single read port of each store: the
// address is presented, then the read data is registered.
// While a search runs s_ready is low. While its result waits for m_ready,
// loads are still accepted but a new start request is held off; a stalled
// m_ready holds the result register.
// Reset clears control state and sets seed 5 and all extents to 256; the
// image stores are not cleared and hold nothing defined until written.
// Registers at byte addresses 0,4,8,12,16: seed_size, width_a, height_a,
// width_b, height_b.
// ============================================================================
module seed_block_match_and_grow_unit import sbmg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SW-1:0] seed_reg;
    logic [DW-1:0] wa_reg, ha_reg, wb_reg, hb_reg;
    logic [2:0]    ridx;
    dp_cmd_t       cmd;
    dp_sts_t       sts;
    logic          busy, res_valid, acc, start;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SW'(5);
            wa_reg <= DW'(256); ha_reg <= DW'(256);
            wb_reg <= DW'(256); hb_reg <= DW'(256);
        end else if (psel && penable && pwrite) begin
            if (ridx == REG_SEED)     seed_reg <= pwdata[SW-1:0];
            if (ridx == REG_WIDTH_A)  wa_reg   <= pwdata[DW-1:0];
            if (ridx == REG_HEIGHT_A) ha_reg   <= pwdata[DW-1:0];
            if (ridx == REG_WIDTH_B)  wb_reg   <= pwdata[DW-1:0];
            if (ridx == REG_HEIGHT_B) hb_reg   <= pwdata[DW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (ridx == REG_SEED)          prdata = 32'(seed_reg);
        else if (ridx == REG_WIDTH_A)  prdata = 32'(wa_reg);
        else if (ridx == REG_HEIGHT_A) prdata = 32'(ha_reg);
        else if (ridx == REG_WIDTH_B)  prdata = 32'(wb_reg);
        else if (ridx == REG_HEIGHT_B) prdata = 32'(hb_reg);
    end

    // loads never touch the held result; only a start waits for it
    assign s_ready = !busy && !(res_valid && s_data.opcode == OP_START);
    assign acc     = s_valid && s_ready;
    assign start   = acc && s_data.opcode == OP_START;

    sbmg_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(start), .sts(sts),
        .res_taken(m_ready), .cmd(cmd), .busy(busy), .res_valid(res_valid)
    );

    sbmg_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .ld_we(acc),
        .ld_item(s_data), .cfg_seed(seed_reg), .cfg_wa(wa_reg), .cfg_ha(ha_reg),
        .cfg_wb(wb_reg), .cfg_hb(hb_reg), .sts(sts), .result(m_data)
    );

    assign m_valid = res_valid;

`ifndef SYNTHESIS
    a_no_start_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && s_data.opcode == OP_START) |-> !s_ready)
        else $error("start accepted while result pending");
    a_start_leads: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready) else $error("start did not block input");
    a_found_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.found) |-> (m_data.match_width != 9'd0 &&
        m_data.match_height != 9'd0)) else $error("found with empty region");
`endif

endmodule
